FILE: hdl/psms_pkg.sv
package psms_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_DIMS   = 4;
  localparam int COORD_W    = 24;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 35;
  localparam int MAG_W      = 34;
  localparam int SQ_W       = 59;
  localparam int WIDE_W     = 72;
  localparam int DSR_W      = 23;
  localparam int NN_W       = 22;
  localparam int ROOT_W     = 48;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [23:0] SCALE_ONE = 24'd4096;
  localparam logic [23:0] SCALE_MAX = 24'hFFFFFF;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_OWN    = 2'd1;
  localparam logic [1:0] MODE_TAKE_X = 2'd2;
  localparam logic [1:0] MODE_TAKE_Y = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  localparam logic REG_DIMS = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic               set_sel;
    logic signed [23:0] coord0;
    logic signed [23:0] coord1;
    logic signed [23:0] coord2;
    logic signed [23:0] coord3;
    logic               last_of_set;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         dim_index;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic [23:0]        scale_x;
    logic [23:0]        scale_y;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                                    set_sel;
    logic [MAX_DIMS-1:0][COORD_W-1:0]        coords;
    logic                                    last_of_set;
    logic [1:0]                              dims_m1;
  } q_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]                 count;
    logic [MAX_DIMS-1:0][SUM_W-1:0]   sums;
    logic [SQ_W-1:0]                  sumsq;
  } set_stats_t;

  typedef struct packed {
    logic       start;
    logic [1:0] dims_m1;
  } fin_req_t;

  typedef enum logic [3:0] {
    FIN_IDLE,
    FIN_MEAN,
    FIN_MEAN_WAIT,
    FIN_SQ_INIT,
    FIN_MUL_A,
    FIN_MUL_B,
    FIN_NN,
    FIN_DIV_GO,
    FIN_DIV_WAIT,
    FIN_ROOT,
    FIN_EMIT
  } fin_state_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] n;
    n = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
    return n[MAG_W-1:0];
  endfunction

endpackage

FILE: hdl/point_set_mean_rms_scale_top.sv
// Centroid and RMS scale of two point sets. Send the points of X, then the
// points of Y, one request per point; the request that carries Y's last mark
// closes the pair and produces one result per used dimension, holding the
// truncated means of X and Y and both RMS scales, after which every sum is
// cleared for the next pair. A four-entry queue parts the input side from
// the accumulator, so requests keep flowing, until it fills, while the back
// end is busy or results wait to be taken. Each point passes through the
// accumulator one coordinate a cycle (through a single squaring multiplier)
// while no closed pair is waiting. Closing a pair runs serial division for
// the means of each non-empty set, then per non-empty set shift-add
// multiplication, one division and, unless its quotient is too large, a square
// root, then emits the results, holding while the receiver stalls. Write
// configuration only while idle.
module point_set_mean_rms_scale_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  psms_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output psms_pkg::out_item_t result
);
  import psms_pkg::*;

  logic [2:0]  dims_in_use;
  logic [1:0]  stat_mode;
  logic [1:0]  dims_m1;

  q_item_t     tagged_item;
  logic        q_full;
  logic        q_head_valid;
  q_item_t     q_head;
  logic        q_pop;
  fin_req_t    req;
  logic        fin_done;
  set_stats_t  stats_x;
  set_stats_t  stats_y;

  // Hold the configuration registers; write takes effect at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 3'd3;
      stat_mode   <= MODE_OWN;
    end else if (cfg_we) begin
      if (cfg_index == REG_DIMS) begin
        dims_in_use <= cfg_data;
      end else begin
        stat_mode <= cfg_data[1:0];
      end
    end
  end

  // Clamp the dimension count: zero acts as one, anything above four as four.
  always_comb begin
    if (dims_in_use == 3'd0) begin
      dims_m1 = 2'd0;
    end else if (dims_in_use > 3'(MAX_DIMS)) begin
      dims_m1 = 2'(MAX_DIMS - 1);
    end else begin
      dims_m1 = 2'(dims_in_use - 3'd1);
    end
  end

  // Front end: tag each request with the dimension count of its own step.
  always_comb begin
    tagged_item.set_sel     = item.set_sel;
    tagged_item.coords[0]   = item.coord0;
    tagged_item.coords[1]   = item.coord1;
    tagged_item.coords[2]   = item.coord2;
    tagged_item.coords[3]   = item.coord3;
    tagged_item.last_of_set = item.last_of_set;
    tagged_item.dims_m1     = dims_m1;
  end

  // Stall the source only when the queue is full.
  assign item_stall = q_full;

  psms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (item_valid && !q_full),
    .push_item  (tagged_item),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  // Back end, part one: count, sum and square the coordinates.
  psms_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .req        (req),
    .done       (fin_done),
    .stats_x    (stats_x),
    .stats_y    (stats_y)
  );

  // Back end, part two: means, scales and the result stream.
  psms_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .mode         (stat_mode),
    .stats_x      (stats_x),
    .stats_y      (stats_y),
    .result_stall (result_stall),
    .done         (fin_done),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: hdl/psms_queue.sv
module psms_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  psms_pkg::q_item_t push_item,
  output logic              full,
  output logic              head_valid,
  output psms_pkg::q_item_t head,
  input  logic              pop
);
  import psms_pkg::*;

  q_item_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     fill;

  assign full       = (fill == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hdl/psms_accum.sv
module psms_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  psms_pkg::q_item_t    head,
  output logic                 pop,
  output psms_pkg::fin_req_t   req,
  input  logic                 done,
  output psms_pkg::set_stats_t stats_x,
  output psms_pkg::set_stats_t stats_y
);
  import psms_pkg::*;

  set_stats_t          stx;
  set_stats_t          sty;
  logic [1:0]          dcnt;
  logic                waiting;

  set_stats_t          cur;
  logic                take;
  logic                item_end;
  logic                work;
  logic signed [23:0]  c;
  logic signed [47:0]  c_sq;
  logic [SUM_W-1:0]    sum_new;
  logic [SQ_W-1:0]     sq_new;

  always_comb begin
    cur      = head.set_sel ? sty : stx;
    take     = (cur.count < CNT_W'(MAX_POINTS));
    c        = $signed(head.coords[dcnt]);
    c_sq     = c * c;
    sum_new  = SUM_W'($signed(cur.sums[dcnt]) + SUM_W'(c));
    sq_new   = cur.sumsq + {11'd0, c_sq};
    item_end = !take || (dcnt == head.dims_m1);
    work     = head_valid && !waiting;
    pop      = work && item_end;
    req.start   = pop && head.set_sel && head.last_of_set;
    req.dims_m1 = head.dims_m1;
  end

  assign stats_x = stx;
  assign stats_y = sty;

  always_ff @(posedge clk) begin
    if (rst || done) begin
      stx     <= '0;
      sty     <= '0;
      dcnt    <= '0;
      waiting <= 1'b0;
    end else if (work) begin
      if (take) begin
        if (head.set_sel) begin
          sty.sums[dcnt] <= sum_new;
          sty.sumsq      <= sq_new;
        end else begin
          stx.sums[dcnt] <= sum_new;
          stx.sumsq      <= sq_new;
        end
      end
      if (item_end) begin
        dcnt <= '0;
        if (take) begin
          if (head.set_sel) begin
            sty.count <= sty.count + CNT_W'(1);
          end else begin
            stx.count <= stx.count + CNT_W'(1);
          end
        end
        if (head.set_sel && head.last_of_set) begin
          waiting <= 1'b1;
        end
      end else begin
        dcnt <= dcnt + 2'd1;
      end
    end
  end

endmodule

FILE: hdl/psms_div.sv
module psms_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [psms_pkg::WIDE_W-1:0]        dividend,
  input  logic [psms_pkg::DSR_W-1:0]         divisor,
  output logic                               done,
  output logic [psms_pkg::WIDE_W-1:0]        quot
);
  import psms_pkg::*;

  localparam logic [6:0] LAST_STEP = 7'(WIDE_W - 1);

  logic [WIDE_W-1:0] dvd;
  logic [DSR_W-1:0]  rem;
  logic [DSR_W-1:0]  dsr;
  logic [6:0]        cnt;
  logic              busy;
  logic [DSR_W:0]    trial;
  logic              ge;

  assign trial = {rem, dvd[WIDE_W-1]};
  assign ge    = (trial >= {1'b0, dsr});
  assign quot  = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[WIDE_W-2:0], ge};
      rem <= ge ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
    end
  end

endmodule

FILE: hdl/psms_finish.sv
module psms_finish (
  input  logic                 clk,
  input  logic                 rst,
  input  psms_pkg::fin_req_t   req,
  input  logic [1:0]           mode,
  input  psms_pkg::set_stats_t stats_x,
  input  psms_pkg::set_stats_t stats_y,
  input  logic                 result_stall,
  output logic                 done,
  output logic                 result_valid,
  output psms_pkg::out_item_t  result
);
  import psms_pkg::*;

  fin_state_t                   state;
  fin_state_t                   state_next;
  logic                         set_idx;
  logic [1:0]                   d_idx;
  logic [1:0]                   dims_m1;
  logic [1:0]                   e_idx;
  logic [MAX_DIMS-1:0][23:0]    means_x;
  logic [MAX_DIMS-1:0][23:0]    means_y;
  logic [1:0][23:0]             scales;
  logic [WIDE_W-1:0]            acc_a;
  logic [WIDE_W-1:0]            acc_b;
  logic [WIDE_W-1:0]            mop;
  logic [MAG_W-1:0]             mbits;
  logic [5:0]                   mcnt;
  logic [NN_W-1:0]              nn;
  logic [ROOT_W-1:0]            root_v;
  logic [ROOT_W-1:0]            root_res;
  logic [ROOT_W-1:0]            root_bit;
  logic [4:0]                   rcnt;

  set_stats_t                   cur;
  logic [MAG_W-1:0]             cur_mag;
  logic [MAG_W-1:0]             nxt_mag;
  logic                         cur_neg;
  logic                         cnt_zero;
  logic                         mean_last;
  logic                         mul_last_a;
  logic                         mul_last_b;
  logic [WIDE_W-1:0]            diff;
  logic [NN_W+2:0]              dsr_full;
  logic                         div_start;
  logic                         div_done;
  logic [WIDE_W-1:0]            div_dividend;
  logic [DSR_W-1:0]             div_divisor;
  logic [WIDE_W-1:0]            div_quot;
  logic                         q_big;
  logic [ROOT_W:0]              root_sum;
  logic                         root_ge;
  logic [ROOT_W-1:0]            res_next;
  logic                         emit_load;
  out_item_t                    item;
  logic [23:0]                  neg_q;

  psms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    cur        = set_idx ? stats_y : stats_x;
    cur_mag    = mag_of(cur.sums[d_idx]);
    nxt_mag    = mag_of(cur.sums[d_idx + 2'd1]);
    cur_neg    = cur.sums[d_idx][SUM_W-1];
    cnt_zero   = (cur.count == '0);
    mean_last  = set_idx && (d_idx == 2'd3);
    mul_last_a = (mcnt == 6'(CNT_W - 1));
    mul_last_b = (mcnt == 6'(MAG_W - 1));
    diff       = (acc_a >= acc_b) ? (acc_a - acc_b) : '0;
    dsr_full   = nn * ({1'b0, dims_m1} + 3'd1);
    q_big      = (div_quot[WIDE_W-1:ROOT_W] != '0);
    root_sum   = {1'b0, root_res} + {1'b0, root_bit};
    root_ge    = ({1'b0, root_v} >= root_sum);
    res_next   = root_ge ? ((root_res >> 1) + root_bit) : (root_res >> 1);
    neg_q      = cur_neg ? (~div_quot[23:0] + 24'd1) : div_quot[23:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FIN_IDLE: begin
        if (req.start) state_next = FIN_MEAN;
      end
      FIN_MEAN: begin
        if (!cnt_zero) state_next = FIN_MEAN_WAIT;
        else if (mean_last) state_next = FIN_SQ_INIT;
      end
      FIN_MEAN_WAIT: begin
        if (div_done) state_next = mean_last ? FIN_SQ_INIT : FIN_MEAN;
      end
      FIN_SQ_INIT: begin
        if (!cnt_zero) state_next = FIN_MUL_A;
        else if (set_idx) state_next = FIN_EMIT;
      end
      FIN_MUL_A: begin
        if (mul_last_a) state_next = FIN_MUL_B;
      end
      FIN_MUL_B: begin
        if (mul_last_b && (d_idx == dims_m1)) state_next = FIN_NN;
      end
      FIN_NN: begin
        state_next = FIN_DIV_GO;
      end
      FIN_DIV_GO: begin
        state_next = FIN_DIV_WAIT;
      end
      FIN_DIV_WAIT: begin
        if (div_done) begin
          if (!q_big) state_next = FIN_ROOT;
          else state_next = set_idx ? FIN_EMIT : FIN_SQ_INIT;
        end
      end
      FIN_ROOT: begin
        if (rcnt == 5'(COORD_W - 1)) state_next = set_idx ? FIN_EMIT : FIN_SQ_INIT;
      end
      FIN_EMIT: begin
        if (done) state_next = FIN_IDLE;
      end
      default: begin
        state_next = FIN_IDLE;
      end
    endcase
  end

  // Control outputs and result assembly.
  always_comb begin
    div_start    = ((state == FIN_MEAN) && !cnt_zero) || (state == FIN_DIV_GO);
    div_dividend = (state == FIN_MEAN) ? WIDE_W'(cur_mag) : diff;
    div_divisor  = (state == FIN_MEAN) ? DSR_W'(cur.count) : dsr_full[DSR_W-1:0];
    emit_load    = (state == FIN_EMIT) && (!result_valid || !result_stall);
    done         = emit_load && (e_idx == dims_m1);

    item.dim_index = e_idx;
    item.mean_x    = $signed(means_x[e_idx]);
    item.mean_y    = $signed(means_y[e_idx]);
    item.scale_x   = scales[0];
    item.scale_y   = scales[1];
    item.status    = ((stats_x.count == '0) || (stats_y.count == '0)) ? ST_EMPTY : ST_OK;
    item.last      = (e_idx == dims_m1);
    case (mode)
      MODE_NONE: begin
        item.mean_x  = '0;
        item.mean_y  = '0;
        item.scale_x = SCALE_ONE;
        item.scale_y = SCALE_ONE;
        item.status  = ST_NONE;
      end
      MODE_TAKE_X: begin
        item.mean_y  = $signed(means_x[e_idx]);
        item.scale_y = scales[0];
      end
      MODE_TAKE_Y: begin
        item.mean_x  = $signed(means_y[e_idx]);
        item.scale_x = scales[1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FIN_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FIN_IDLE: begin
        if (req.start) begin
          dims_m1 <= req.dims_m1;
          set_idx <= 1'b0;
          d_idx   <= '0;
          e_idx   <= '0;
        end
      end
      FIN_MEAN: begin
        if (cnt_zero) begin
          if (set_idx) means_y[d_idx] <= '0;
          else means_x[d_idx] <= '0;
          {set_idx, d_idx} <= {set_idx, d_idx} + 3'd1;
        end
      end
      FIN_MEAN_WAIT: begin
        if (div_done) begin
          if (set_idx) means_y[d_idx] <= neg_q;
          else means_x[d_idx] <= neg_q;
          {set_idx, d_idx} <= {set_idx, d_idx} + 3'd1;
        end
      end
      FIN_SQ_INIT: begin
        if (cnt_zero) begin
          scales[set_idx] <= '0;
          set_idx         <= 1'b1;
        end else begin
          acc_a <= '0;
          acc_b <= '0;
          mop   <= WIDE_W'(cur.sumsq);
          mbits <= MAG_W'(cur.count);
          mcnt  <= '0;
          d_idx <= '0;
        end
      end
      FIN_MUL_A: begin
        if (mbits[0]) acc_a <= acc_a + mop;
        if (mul_last_a) begin
          mcnt  <= '0;
          mop   <= WIDE_W'(cur_mag);
          mbits <= cur_mag;
        end else begin
          mop   <= mop << 1;
          mbits <= mbits >> 1;
          mcnt  <= mcnt + 6'd1;
        end
      end
      FIN_MUL_B: begin
        if (mbits[0]) acc_b <= acc_b + mop;
        if (mul_last_b) begin
          mcnt  <= '0;
          d_idx <= d_idx + 2'd1;
          mop   <= WIDE_W'(nxt_mag);
          mbits <= nxt_mag;
        end else begin
          mop   <= mop << 1;
          mbits <= mbits >> 1;
          mcnt  <= mcnt + 6'd1;
        end
      end
      FIN_NN: begin
        nn <= NN_W'(cur.count) * NN_W'(cur.count);
      end
      FIN_DIV_WAIT: begin
        if (div_done) begin
          if (q_big) begin
            scales[set_idx] <= SCALE_MAX;
            set_idx         <= 1'b1;
          end else begin
            root_v   <= div_quot[ROOT_W-1:0];
            root_res <= '0;
            root_bit <= ROOT_W'(1) << (ROOT_W - 2);
            rcnt     <= '0;
          end
        end
      end
      FIN_ROOT: begin
        if (root_ge) root_v <= ROOT_W'(root_v - root_sum[ROOT_W-1:0]);
        root_res <= res_next;
        root_bit <= root_bit >> 2;
        rcnt     <= rcnt + 5'd1;
        if (rcnt == 5'(COORD_W - 1)) begin
          scales[set_idx] <= res_next[23:0];
          set_idx         <= 1'b1;
        end
      end
      FIN_EMIT: begin
        if (emit_load) begin
          result <= item;
          e_idx  <= e_idx + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: tb/point_set_mean_rms_scale_top_tb.sv
module point_set_mean_rms_scale_top_tb;
  import psms_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1200;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic      cfg_index;
  logic [2:0] cfg_data;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item;
  logic      result_valid;
  logic      result_stall;
  out_item_t result;

  point_set_mean_rms_scale_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // Predictor state: a private copy of the accumulators and registers
  logic [2:0]   dims_reg;
  logic [1:0]   mode_reg;
  int unsigned  cnt_x, cnt_y;
  longint       sx_acc[4], sy_acc[4];
  logic [63:0]  sq_x, sq_y;

  out_item_t    expected_results[$];
  int           fail_count;
  bit           quiet_tail;
  bit           hold_off_req;
  int           idle_run;

  // Row of the directed stimulus; has_gold marks rows with a typed-in answer
  typedef struct {
    in_item_t  req;
    bit        has_gold;
    out_item_t gold;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic int dims_eff();
    if (dims_reg == 0) return 1;
    return (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
  endfunction

  function automatic longint coord_of(in_item_t r, int d);
    case (d)
      0: return longint'(r.coord0);
      1: return longint'(r.coord1);
      2: return longint'(r.coord2);
      default: return longint'(r.coord3);
    endcase
  endfunction

  function automatic logic [23:0] rms_of(int unsigned n, longint sums[4], logic [63:0] sq,
                                         int dims);
    logic [127:0] a, b, q;
    logic [63:0]  v, res, bitv, m;
    if (n == 0) return 24'd0;
    a = 128'(n) * 128'(sq);
    b = '0;
    for (int d = 0; d < dims; d++) begin
      m = (sums[d] < 0) ? 64'(-sums[d]) : 64'(sums[d]);
      b += 128'(m) * 128'(m);
    end
    a = (b > a) ? 128'd0 : a - b;
    q = a / (128'(n) * 128'(n) * 128'(dims));
    v = (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return (res > 64'hFFFFFF) ? SCALE_MAX : res[23:0];
  endfunction

  task automatic clear_sums();
    cnt_x = 0; cnt_y = 0; sq_x = 0; sq_y = 0;
    for (int d = 0; d < 4; d++) begin
      sx_acc[d] = 0; sy_acc[d] = 0;
    end
  endtask

  // Accumulate one point, and on Y's last mark queue the closing results
  task automatic predict_centroid(in_item_t r);
    int dims;
    longint c, mx[4], my[4];
    logic [23:0] scx, scy;
    logic [1:0] st;
    out_item_t o;
    dims = dims_eff();
    if (r.set_sel ? (cnt_y < MAX_POINTS) : (cnt_x < MAX_POINTS)) begin
      for (int d = 0; d < dims; d++) begin
        c = coord_of(r, d);
        if (r.set_sel) begin
          sy_acc[d] += c; sq_y += 64'(c * c);
        end else begin
          sx_acc[d] += c; sq_x += 64'(c * c);
        end
      end
      if (r.set_sel) cnt_y++; else cnt_x++;
    end
    if (!(r.set_sel && r.last_of_set)) return;
    for (int d = 0; d < 4; d++) begin
      mx[d] = cnt_x ? sx_acc[d] / longint'(cnt_x) : 0;
      my[d] = cnt_y ? sy_acc[d] / longint'(cnt_y) : 0;
    end
    if (mode_reg == MODE_NONE) begin
      for (int d = 0; d < 4; d++) begin
        mx[d] = 0; my[d] = 0;
      end
      scx = SCALE_ONE; scy = SCALE_ONE; st = ST_NONE;
    end else begin
      scx = rms_of(cnt_x, sx_acc, sq_x, dims);
      scy = rms_of(cnt_y, sy_acc, sq_y, dims);
      st = (cnt_x == 0 || cnt_y == 0) ? ST_EMPTY : ST_OK;
      if (mode_reg == MODE_TAKE_X) begin
        my = mx; scy = scx;
      end
      if (mode_reg == MODE_TAKE_Y) begin
        mx = my; scx = scy;
      end
    end
    for (int d = 0; d < dims; d++) begin
      o.dim_index = 2'(d);
      o.mean_x = 24'(mx[d]);
      o.mean_y = 24'(my[d]);
      o.scale_x = scx;
      o.scale_y = scy;
      o.status = st;
      o.last = (d + 1 == dims);
      expected_results.push_back(o);
    end
    clear_sums();
  endtask

  function automatic in_item_t point_of(bit ysel, bit lst, logic [23:0] c0, logic [23:0] c1,
                                        logic [23:0] c2, logic [23:0] c3);
    in_item_t r;
    r.set_sel = ysel; r.last_of_set = lst;
    r.coord0 = c0; r.coord1 = c1; r.coord2 = c2; r.coord3 = c3;
    return r;
  endfunction

  function automatic in_item_t rand_point(bit ysel, bit lst);
    in_item_t r;
    r = point_of(ysel, lst, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    // Keep some points near the origin so the means are not pure noise
    if ($urandom_range(0, 2) == 0) begin
      r.coord0 = 24'($signed($urandom_range(0, 8191)) - 4096);
      r.coord1 = 24'($signed($urandom_range(0, 8191)) - 4096);
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no progress", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, result);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result !== want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, result);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none at the tail
  initial begin
    int n;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        hold_off_req = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        result_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted; predict on acceptance.
  // Valid stays up afterwards so the next request can follow at once.
  task automatic send_point(in_item_t r);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= r;
    do @(posedge clk); while (item_stall);
    predict_centroid(r);
    @(negedge clk);
  endtask

  // Drain pending results, then let the closing pass finish before a write
  task automatic write_reg(logic idx, logic [2:0] val);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIMS) dims_reg = val; else mode_reg = val[1:0];
  endtask

  task automatic add_row(in_item_t r, bit has, out_item_t g);
    stim_row_t s;
    s.req = r; s.has_gold = has; s.gold = g;
    directed_rows.push_back(s);
  endtask

  initial begin
    out_item_t g, none_g;
    int sent, npts;
    logic [2:0] dsel;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    item_valid = 1'b0; item = '0;
    fail_count = 0; quiet_tail = 0; hold_off_req = 0; idle_run = 0;
    dims_reg = 3'd3; mode_reg = MODE_OWN;
    clear_sums();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    none_g = '0;
    // X empty after reset, Y a single origin point: zero means and scales, empty status
    g = '0; g.status = ST_EMPTY;
    add_row(point_of(1, 1, 0, 0, 0, 0), 0, none_g);
    // Single-point sets at the coordinate extremes: zero spread
    add_row(point_of(0, 1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000), 0, none_g);
    g = '0; g.mean_x = 24'h7FFFFF; g.mean_y = 24'h800000; g.status = ST_OK;
    add_row(point_of(1, 1, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF), 1, g);
    // Opposite extremes within X: large spread, mean truncates to zero from -1/2
    add_row(point_of(0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF), 0, none_g);
    add_row(point_of(0, 1, 24'h800000, 24'h800000, 24'h800000, 24'h800000), 0, none_g);
    add_row(point_of(1, 0, 24'hFFFFFF, 24'h000001, 24'h000003, 24'hFFFFFD), 0, none_g);
    add_row(point_of(1, 0, 24'h000002, 24'hFFFFFE, 24'h000000, 24'hFFFFFF), 0, none_g);
    add_row(point_of(1, 1, 24'h000000, 24'h000000, 24'hFFF000, 24'h001000), 0, none_g);
    // Empty X with a non-empty Y
    add_row(point_of(1, 0, 24'h001000, 24'h002000, 24'h003000, 24'h0), 0, none_g);
    add_row(point_of(1, 1, 24'hFFF000, 24'h000000, 24'h001000, 24'h0), 0, none_g);

    foreach (directed_rows[i]) begin
      send_point(directed_rows[i].req);
      if (directed_rows[i].has_gold) begin
        g = directed_rows[i].gold;
        // Results of the row are the tail of the queue; check the first against the typed-in answer
        if (expected_results.size() < 3 ||
            expected_results[expected_results.size()-3] !== g) begin
          $display("%0t directed row %0d: expected %p actual %p", $time, i, g,
                   expected_results[expected_results.size()-3]);
          fail_count++;
        end
      end
    end
    g = '0; g.status = ST_EMPTY; g.last = 0;
    // The first row closed with X empty; its result has no typed-in copy and is
    // checked by the predictor queue against the block

    // Walk the register settings, extremes first, then random pairs of sets
    sent = 0;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: dsel = 3'd1;
        1: dsel = 3'd4;
        2: dsel = 3'd0;
        3: dsel = 3'd7;
        default: dsel = 3'($urandom_range(0, 7));
      endcase
      write_reg(REG_DIMS, dsel);
      write_reg(REG_MODE, 3'(phase % 4));
      if (phase == 10) quiet_tail = 1;
      for (int pair = 0; pair < 5; pair++) begin
        if (phase == 5 && pair == 1) hold_off_req = 1;
        // Mostly well-formed pairs; sometimes a stray X mark
        npts = $urandom_range(0, 6);
        if ($urandom_range(0, 7) != 0 || npts == 0) npts = npts + 1;
        for (int k = 0; k < npts; k++) begin
          send_point(rand_point(0, (k == npts - 1) || ($urandom_range(0, 9) == 0)));
          sent++;
        end
        npts = $urandom_range(1, 6);
        for (int k = 0; k < npts; k++) begin
          send_point(rand_point(1, k == npts - 1));
          sent++;
        end
        // Noise: now and then a point of a random set, then a Y point with the last mark
        if ($urandom_range(0, 5) == 0) begin
          send_point(rand_point($urandom_range(0, 1), 0));
          send_point(rand_point(1, 1));
          sent += 2;
        end
      end
    end

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/psms_pkg.sv
hdl/psms_queue.sv
hdl/psms_accum.sv
hdl/psms_div.sv
hdl/psms_finish.sv
hdl/point_set_mean_rms_scale_top.sv
tb/point_set_mean_rms_scale_top_tb.sv
